// ===== src/sls_pkg.sv =====
// ---------------------------------------------------------------------------
// sls_pkg: shared types and constants for the shifting list store
// capacity, field widths, operation and status codes, control structs
// ---------------------------------------------------------------------------
package sls_pkg;

	localparam int CAPACITY   = 16;
	localparam int ITEM_BITS  = 8;
	localparam int IDX_BITS   = $clog2(CAPACITY);
	localparam int COUNT_BITS = $clog2(CAPACITY + 1);
	localparam int OP_BITS    = 3;
	localparam int POS_BITS   = 4;
	localparam int STAT_BITS  = 2;

	// operation codes
	localparam logic [OP_BITS-1:0] OP_PUSH    = 3'd0;
	localparam logic [OP_BITS-1:0] OP_POP     = 3'd1;
	localparam logic [OP_BITS-1:0] OP_INS_AT  = 3'd2;
	localparam logic [OP_BITS-1:0] OP_REM_AT  = 3'd3;
	localparam logic [OP_BITS-1:0] OP_INS_MID = 3'd4;
	localparam logic [OP_BITS-1:0] OP_REM_MID = 3'd5;

	// status codes
	localparam logic [STAT_BITS-1:0] STAT_DONE   = 2'd0;
	localparam logic [STAT_BITS-1:0] STAT_FULL   = 2'd1;
	localparam logic [STAT_BITS-1:0] STAT_EMPTY  = 2'd2;
	localparam logic [STAT_BITS-1:0] STAT_BADPOS = 2'd3;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;   // capture the incoming operation
		logic exec;   // apply it and load the result register
	} dp_cmd_t;

endpackage

// ===== src/sls_ctrl.sv =====
// ---------------------------------------------------------------------------
// sls_ctrl: controller for the shifting list store
// sequences capture and execution, tracks the result register
// ---------------------------------------------------------------------------
module sls_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output sls_pkg::dp_cmd_t cmd
);

	sls_pkg::state_t state_q, state_nxt;
	logic            out_valid_q;
	logic            exec_ok;

	// result register free or draining this cycle
	assign exec_ok = !out_valid_q || out_ready;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			sls_pkg::ST_IDLE: begin
				if (in_valid) state_nxt = sls_pkg::ST_EXEC;
			end
			sls_pkg::ST_EXEC: begin
				if (exec_ok) state_nxt = sls_pkg::ST_IDLE;
			end
			default: state_nxt = sls_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			sls_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			sls_pkg::ST_EXEC: begin
				cmd.exec = exec_ok;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sls_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.exec) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== src/sls_dp.sv =====
// ---------------------------------------------------------------------------
// sls_dp: datapath for the shifting list store
// row of item cells that shift in parallel, fill count, result register
// ---------------------------------------------------------------------------
module sls_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  sls_pkg::dp_cmd_t                 cmd,
	input  logic [sls_pkg::OP_BITS-1:0]      op,
	input  logic [sls_pkg::POS_BITS-1:0]     position,
	input  logic [sls_pkg::ITEM_BITS-1:0]    new_item,
	output logic [sls_pkg::STAT_BITS-1:0]    status,
	output logic [sls_pkg::ITEM_BITS-1:0]    removed_item,
	output logic [sls_pkg::COUNT_BITS-1:0]   item_count
);

	localparam int CB = sls_pkg::COUNT_BITS;
	localparam int IB = sls_pkg::ITEM_BITS;

	// captured operation
	logic [sls_pkg::OP_BITS-1:0]  op_q;
	logic [sls_pkg::POS_BITS-1:0] pos_q;
	logic [IB-1:0]                item_q;

	logic [CB-1:0] count_q;
	logic [IB-1:0] cell_q [sls_pkg::CAPACITY];

	// result register
	logic [sls_pkg::STAT_BITS-1:0] status_q;
	logic [IB-1:0]                 removed_q;
	logic [CB-1:0]                 rcount_q;

	logic [sls_pkg::STAT_BITS-1:0] stat_c;
	logic                          ins_c, rem_c, pop_c;
	logic [CB-1:0]                 at_c;
	logic [CB-1:0]                 pos_ext;
	logic [CB-1:0]                 count_nxt;
	logic                          full, empty;
	logic [sls_pkg::IDX_BITS-1:0]  last_idx;
	logic [IB-1:0]                 removed_c;

	assign pos_ext  = CB'(pos_q);
	assign full     = count_q == CB'(sls_pkg::CAPACITY);
	assign empty    = count_q == '0;
	assign last_idx = sls_pkg::IDX_BITS'(count_q - 1'b1);

	always_comb begin
		stat_c = sls_pkg::STAT_DONE;
		ins_c  = 1'b0;
		rem_c  = 1'b0;
		pop_c  = 1'b0;
		at_c   = count_q;
		case (op_q)
			sls_pkg::OP_PUSH: begin
				if (full) stat_c = sls_pkg::STAT_FULL;
				else ins_c = 1'b1;
			end
			sls_pkg::OP_POP: begin
				if (empty) stat_c = sls_pkg::STAT_EMPTY;
				else pop_c = 1'b1;
			end
			sls_pkg::OP_INS_AT: begin
				at_c = pos_ext;
				if (pos_ext >= count_q) stat_c = sls_pkg::STAT_BADPOS;
				else if (full) stat_c = sls_pkg::STAT_FULL;
				else ins_c = 1'b1;
			end
			sls_pkg::OP_REM_AT: begin
				at_c = pos_ext;
				if (empty) stat_c = sls_pkg::STAT_EMPTY;
				else if (pos_ext >= count_q) stat_c = sls_pkg::STAT_BADPOS;
				else rem_c = 1'b1;
			end
			sls_pkg::OP_INS_MID: begin
				at_c = count_q >> 1;
				if (full) stat_c = sls_pkg::STAT_FULL;
				else ins_c = 1'b1;
			end
			sls_pkg::OP_REM_MID: begin
				at_c = count_q >> 1;
				if (empty) stat_c = sls_pkg::STAT_EMPTY;
				else rem_c = 1'b1;
			end
			default: stat_c = sls_pkg::STAT_BADPOS;
		endcase
	end

	always_comb begin
		count_nxt = count_q;
		if (ins_c) count_nxt = count_q + 1'b1;
		else if (rem_c || pop_c) count_nxt = count_q - 1'b1;
	end

	assign removed_c = pop_c ? cell_q[last_idx] : '0;

	// each cell compares its own position with the target and moves in parallel
	for (genvar i = 0; i < sls_pkg::CAPACITY; i++) begin : g_cell
		localparam logic [CB-1:0] IDX = CB'(i);
		logic [IB-1:0] from_below;
		logic [IB-1:0] from_above;

		if (i == 0) begin : g_first
			assign from_below = item_q;
		end else begin : g_mid_lo
			assign from_below = cell_q[i-1];
		end
		if (i == sls_pkg::CAPACITY - 1) begin : g_last
			assign from_above = cell_q[i];
		end else begin : g_mid_hi
			assign from_above = cell_q[i+1];
		end

		always_ff @(posedge clk) begin
			if (cmd.exec) begin
				if (ins_c) begin
					if (IDX == at_c) cell_q[i] <= item_q;
					else if (IDX > at_c && IDX <= count_q) cell_q[i] <= from_below;
				end else if (rem_c) begin
					if (IDX >= at_c && IDX + 1'b1 < count_q) cell_q[i] <= from_above;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= op;
			pos_q  <= position;
			item_q <= new_item;
		end
		if (cmd.exec) begin
			status_q  <= stat_c;
			removed_q <= removed_c;
			rcount_q  <= count_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			count_q <= count_nxt;
		end
	end

	assign status       = status_q;
	assign removed_item = removed_q;
	assign item_count   = rcount_q;

endmodule

// ===== src/shifting_list_store.sv =====
// ---------------------------------------------------------------------------
// shifting_list_store: ordered store of up to 16 items packed from position 0
// push, pop, insert or remove at a position or at the middle, one result each
// ---------------------------------------------------------------------------
//
//  channel   direction  payload (tdata, lowest bit first)
//  s_*       in         op[2:0], position[6:3], new_item[14:7], zero[15]
//  m_*       out        status[1:0], removed_item[9:2], item_count[14:10], zero[15]
//
// an operation is captured in ST_IDLE, then applied in ST_EXEC, in which
// all cells shift at once and the result register loads
// ST_EXEC waits while an earlier result is still unclaimed, so a
// stall on m_* holds at most one item in flight behind the result register
// a new operation is taken while a finished result waits on m_*
// reset empties the store; cell contents are left as they were
//
module shifting_list_store (
	input  logic        clk,
	input  logic        arst_n,
	// operation in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // op[2:0], position[6:3], new_item[14:7]
	// result out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // status[1:0], removed_item[9:2], item_count[14:10]
);

	sls_pkg::dp_cmd_t cmd;

	logic [sls_pkg::STAT_BITS-1:0]  status;
	logic [sls_pkg::ITEM_BITS-1:0]  removed_item;
	logic [sls_pkg::COUNT_BITS-1:0] item_count;

	// controller: capture on a transfer, execute when the result slot frees
	sls_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd)
	);

	// datapath: cell row, fill count, result register
	sls_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.op           (s_tdata[2:0]),
		.position     (s_tdata[6:3]),
		.new_item     (s_tdata[14:7]),
		.status       (status),
		.removed_item (removed_item),
		.item_count   (item_count)
	);

	// pack result fields, top bit pads to a whole byte
	assign m_tdata = {1'b0, item_count, removed_item, status};

endmodule

// ===== verif/tb.sv =====
// ---------------------------------------------------------------------------
// tb: self-checking bench for the shifting list store
// a short table of directed operations, then about 700 random operations in
// phases that fill, drain, mix or throw noise at the store; each result is
// checked against the table's literal answer or a behavioral copy of the list
// ---------------------------------------------------------------------------
module tb;

	localparam int OPB  = sls_pkg::OP_BITS;
	localparam int POSB = sls_pkg::POS_BITS;
	localparam int ITB  = sls_pkg::ITEM_BITS;
	localparam int CNTB = sls_pkg::COUNT_BITS;
	localparam int STB  = sls_pkg::STAT_BITS;
	localparam int CAP  = sls_pkg::CAPACITY;

	// codes with no operation behind them, rejected as bad position
	localparam logic [OPB-1:0] OP_RSVD_A = 3'd6;
	localparam logic [OPB-1:0] OP_RSVD_B = 3'd7;

	localparam int DIRECTED_ROWS = 24;
	localparam int RANDOM_ITEMS  = 700;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 400000;

	typedef struct packed {
		logic [STB-1:0]  status;
		logic [ITB-1:0]  removed;
		logic [CNTB-1:0] count;
	} list_result_t;

	typedef struct packed {
		logic [OPB-1:0]  op;
		logic [POSB-1:0] pos;
		logic [ITB-1:0]  item;
		logic            typed;   // want holds the literal answer
		list_result_t    want;
	} stim_row_t;

	typedef enum {
		MODE_FILL,
		MODE_DRAIN,
		MODE_MIX,
		MODE_NOISE
	} traffic_mode_t;

	localparam list_result_t ANY_RESULT = '0;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;

	// behavioral copy of the list
	logic [ITB-1:0]  shadow_items [CAP];
	logic [CNTB-1:0] shadow_count;

	list_result_t pending_results [$];
	int           error_count = 0;
	int           cycle_count = 0;
	int           rx_stall_left = 0;
	int           rx_quiet_left = 0;

	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		// empty store: every removal and every positioned insert is refused
		'{sls_pkg::OP_POP,     4'd0,  8'h00, 1'b1, '{sls_pkg::STAT_EMPTY,  8'h00, 5'd0}},
		'{sls_pkg::OP_REM_MID, 4'd0,  8'h00, 1'b1, '{sls_pkg::STAT_EMPTY,  8'h00, 5'd0}},
		'{sls_pkg::OP_REM_AT,  4'd15, 8'h00, 1'b1, '{sls_pkg::STAT_EMPTY,  8'h00, 5'd0}},
		'{sls_pkg::OP_INS_AT,  4'd0,  8'h55, 1'b1, '{sls_pkg::STAT_BADPOS, 8'h00, 5'd0}},
		'{OP_RSVD_A,           4'd0,  8'h00, 1'b1, '{sls_pkg::STAT_BADPOS, 8'h00, 5'd0}},
		'{OP_RSVD_B,           4'd15, 8'hFF, 1'b1, '{sls_pkg::STAT_BADPOS, 8'h00, 5'd0}},
		'{sls_pkg::OP_PUSH,    4'd0,  8'hFF, 1'b1, '{sls_pkg::STAT_DONE,   8'h00, 5'd1}},
		'{sls_pkg::OP_PUSH,    4'd15, 8'h00, 1'b1, '{sls_pkg::STAT_DONE,   8'h00, 5'd2}},
		'{sls_pkg::OP_INS_MID, 4'd0,  8'hA5, 1'b0, ANY_RESULT},
		'{sls_pkg::OP_INS_AT,  4'd0,  8'h5A, 1'b0, ANY_RESULT},
		// position equal to the count is one past the end
		'{sls_pkg::OP_INS_AT,  4'd4,  8'h11, 1'b1, '{sls_pkg::STAT_BADPOS, 8'h00, 5'd4}},
		'{sls_pkg::OP_REM_AT,  4'd15, 8'h00, 1'b1, '{sls_pkg::STAT_BADPOS, 8'h00, 5'd4}},
		'{OP_RSVD_B,           4'd0,  8'h00, 1'b1, '{sls_pkg::STAT_BADPOS, 8'h00, 5'd4}},
		'{sls_pkg::OP_INS_AT,  4'd3,  8'h3C, 1'b0, ANY_RESULT},
		'{sls_pkg::OP_REM_AT,  4'd0,  8'h00, 1'b0, ANY_RESULT},
		'{sls_pkg::OP_REM_MID, 4'd0,  8'h00, 1'b0, ANY_RESULT},
		'{sls_pkg::OP_POP,     4'd0,  8'h00, 1'b0, ANY_RESULT},
		'{sls_pkg::OP_PUSH,    4'd0,  8'h81, 1'b0, ANY_RESULT},
		'{sls_pkg::OP_INS_MID, 4'd0,  8'h7E, 1'b0, ANY_RESULT},
		'{sls_pkg::OP_POP,     4'd0,  8'h00, 1'b0, ANY_RESULT},
		'{sls_pkg::OP_POP,     4'd0,  8'h00, 1'b0, ANY_RESULT},
		'{sls_pkg::OP_POP,     4'd0,  8'h00, 1'b0, ANY_RESULT},
		'{sls_pkg::OP_POP,     4'd0,  8'h00, 1'b0, ANY_RESULT},
		'{sls_pkg::OP_POP,     4'd0,  8'h00, 1'b1, '{sls_pkg::STAT_EMPTY,  8'h00, 5'd0}}
	};

	shifting_list_store i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// shift entries at and above the slot up by one, then fill the slot
	function automatic void open_slot(logic [CNTB-1:0] at, logic [ITB-1:0] item);
		for (int i = int'(shadow_count); i > int'(at); i--)
			shadow_items[i] = shadow_items[i-1];
		shadow_items[at] = item;
		shadow_count     = shadow_count + 1'b1;
	endfunction

	// shift entries above the slot down by one
	function automatic void close_slot(logic [CNTB-1:0] at);
		for (int i = int'(at); i + 1 < int'(shadow_count); i++)
			shadow_items[i] = shadow_items[i+1];
		shadow_count = shadow_count - 1'b1;
	endfunction

	function automatic list_result_t apply_list_op(logic [OPB-1:0] op,
			logic [POSB-1:0] pos, logic [ITB-1:0] item);
		list_result_t res;
		logic         full;
		logic         empty;
		res.status = sls_pkg::STAT_DONE;
		res.removed = '0;
		full  = (shadow_count >= CAP);
		empty = (shadow_count == 0);
		case (op)
			sls_pkg::OP_PUSH: begin
				if (full) res.status = sls_pkg::STAT_FULL;
				else open_slot(shadow_count, item);
			end
			sls_pkg::OP_POP: begin
				if (empty) res.status = sls_pkg::STAT_EMPTY;
				else begin
					res.removed  = shadow_items[shadow_count - 1'b1];
					shadow_count = shadow_count - 1'b1;
				end
			end
			sls_pkg::OP_INS_AT: begin
				// position check wins over the full check
				if (pos >= shadow_count) res.status = sls_pkg::STAT_BADPOS;
				else if (full) res.status = sls_pkg::STAT_FULL;
				else open_slot(CNTB'(pos), item);
			end
			sls_pkg::OP_REM_AT: begin
				if (empty) res.status = sls_pkg::STAT_EMPTY;
				else if (pos >= shadow_count) res.status = sls_pkg::STAT_BADPOS;
				else close_slot(CNTB'(pos));
			end
			sls_pkg::OP_INS_MID: begin
				if (full) res.status = sls_pkg::STAT_FULL;
				else open_slot(shadow_count >> 1, item);
			end
			sls_pkg::OP_REM_MID: begin
				if (empty) res.status = sls_pkg::STAT_EMPTY;
				else close_slot(shadow_count >> 1);
			end
			default: res.status = sls_pkg::STAT_BADPOS;
		endcase
		res.count = shadow_count;
		return res;
	endfunction

	// idle length: mostly none, some short, a few long
	function automatic int pick_idle(bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	function automatic logic [OPB-1:0] choose_op(traffic_mode_t mode);
		int r;
		r = $urandom_range(0, 9);
		case (mode)
			MODE_FILL: begin
				if (r < 4) return sls_pkg::OP_PUSH;
				if (r < 6) return sls_pkg::OP_INS_AT;
				if (r < 8) return sls_pkg::OP_INS_MID;
				if (r == 8) return sls_pkg::OP_POP;
				return sls_pkg::OP_REM_AT;
			end
			MODE_DRAIN: begin
				if (r < 4) return sls_pkg::OP_POP;
				if (r < 6) return sls_pkg::OP_REM_AT;
				if (r < 8) return sls_pkg::OP_REM_MID;
				if (r == 8) return sls_pkg::OP_PUSH;
				return sls_pkg::OP_INS_AT;
			end
			MODE_MIX: return OPB'($urandom_range(sls_pkg::OP_PUSH, sls_pkg::OP_REM_MID));
			default:  return OPB'($urandom_range(0, 7));
		endcase
	endfunction

	// one operation transfer, preceded by an optional idle gap
	task automatic send_op(logic [OPB-1:0] op, logic [POSB-1:0] pos,
			logic [ITB-1:0] item, logic typed, list_result_t want, int gap);
		list_result_t predicted;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, item, pos, op};
		do @(posedge clk); while (!s_tready);
		predicted = apply_list_op(op, pos, item);
		pending_results.push_back(typed ? want : predicted);
	endtask

	// wait with the sender idle until every expected result has come back
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	initial begin
		traffic_mode_t    mode;
		logic [OPB-1:0]   op;
		logic [POSB-1:0]  pos;
		logic [ITB-1:0]   item;
		bit               quiet;
		int               sent;
		int               phase;
		int               phase_len;
		int               r;

		shadow_count = '0;
		for (int i = 0; i < CAP; i++)
			shadow_items[i] = '0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_op(directed_rows[i].op, directed_rows[i].pos, directed_rows[i].item,
				directed_rows[i].typed, directed_rows[i].want, pick_idle(1'b0));

		sent  = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			// open with a fill then a drain so the full and empty edges are hit early
			if (phase == 0) mode = MODE_FILL;
			else if (phase == 1) mode = MODE_DRAIN;
			else mode = traffic_mode_t'($urandom_range(0, 3));
			quiet     = ($urandom_range(0, 3) == 0);
			phase_len = $urandom_range(10, 60);
			for (int n = 0; n < phase_len && sent < RANDOM_ITEMS; n++) begin
				op  = choose_op(mode);
				pos = POSB'($urandom_range(0, 15));
				if ((op == sls_pkg::OP_INS_AT || op == sls_pkg::OP_REM_AT) &&
						mode != MODE_NOISE && shadow_count != 0 &&
						$urandom_range(0, 9) < 8)
					pos = POSB'($urandom_range(0, int'(shadow_count) - 1));
				r = $urandom_range(0, 9);
				if (r == 0) item = '0;
				else if (r == 1) item = '1;
				else item = ITB'($urandom_range(0, 255));
				send_op(op, pos, item, 1'b0, ANY_RESULT, pick_idle(quiet));
				sent++;
			end
			if (phase == 1 || $urandom_range(0, 4) == 0)
				wait_for_results();
			phase++;
		end

		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("[shifting_list_store] OK");
		else
			$display("[shifting_list_store] ERROR");
		$finish;
	end

	// result side: check each transfer, then choose the next ready value
	always @(posedge clk) begin
		list_result_t got;
		list_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.status  = m_tdata[1:0];
			got.removed = m_tdata[9:2];
			got.count   = m_tdata[14:10];
			if (pending_results.size() == 0) begin
				$error("result transfer with nothing expected: %h", m_tdata);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, got.status);
					error_count++;
				end
				if (got.removed !== want.removed) begin
					$error("removed_item: expected %h, actual %h", want.removed, got.removed);
					error_count++;
				end
				if (got.count !== want.count) begin
					$error("item_count: expected %0d, actual %0d", want.count, got.count);
					error_count++;
				end
			end
		end
		if (rx_stall_left > 0) begin
			rx_stall_left--;
			m_tready <= 1'b0;
		end else if (rx_quiet_left > 0) begin
			rx_quiet_left--;
			m_tready <= 1'b1;
		end else if ($urandom_range(0, 19) == 0) begin
			rx_quiet_left = $urandom_range(50, 200);
			m_tready <= 1'b1;
		end else begin
			rx_stall_left = pick_idle(1'b0);
			m_tready <= (rx_stall_left == 0);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[shifting_list_store] ERROR");
			$finish;
		end
	end

endmodule

// ===== filelist.f =====
src/sls_pkg.sv
src/sls_ctrl.sv
src/sls_dp.sv
src/shifting_list_store.sv
verif/tb.sv
